>>> hw/rtl/stir_gesture_scroll_detector_defines.svh
// assertion macros shared by the stir scroll detector
`ifndef STIR_GESTURE_SCROLL_DETECTOR_DEFINES_SVH
`define STIR_GESTURE_SCROLL_DETECTOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define SGS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sgs_pkg.sv
// types, constants and tables of the stir scroll detector
package sgs_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 12;

   // turn angle width: |angle| stays below 4 rad
   localparam int DTH_W    = ANGLE_FRAC_BITS + 4;
   localparam int CORDIC_W = 38;
   localparam int Z_W      = 34;
   localparam int PROD_W   = 34;
   localparam int SQ_IN_W  = 40;
   localparam int SQ_OUT_W = 20;
   localparam int CMP_W    = 24 + ANGLE_FRAC_BITS + 8;

   localparam logic [Z_W-1:0] Q30_HALF_PI = Z_W'(1686629713);
   localparam logic [23:0]    ANG_THR     = 24'((3 << ANGLE_FRAC_BITS) / 10);

   typedef enum logic [1:0] {
      CLS_OFF,
      CLS_BUTTON,
      CLS_NOISE,
      CLS_MOTION
   } cls_type;

   typedef enum logic [2:0] {
      CSR_ENTER_ANGLE,
      CSR_MAX_RADIUS,
      CSR_MIN_PATH,
      CSR_STROKE_MAX_MS,
      CSR_SCROLL_IDLE_MS,
      CSR_STROKE_GAP_MS,
      CSR_EXIT_COOLDOWN_MS,
      CSR_MAX_DISPLACE
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_AGE,
      ST_PROD,
      ST_WAIT,
      ST_ACCUM,
      ST_DISP,
      ST_CHECK,
      ST_SCROLL,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [7:0]  wheel_v;
      logic signed [7:0]  wheel_h;
      logic               buttons_held;
      logic               drag_mode;
      logic               detect_enabled;
      logic [15:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [7:0]  out_h;
      logic signed [7:0]  out_v;
      logic               scroll_active;
   } rsp_type;

   typedef struct packed {
      logic [16:0] enter_angle;
      logic [11:0] max_radius;
      logic [15:0] min_path;
      logic [15:0] stroke_max_ms;
      logic [15:0] scroll_idle_ms;
      logic [15:0] stroke_gap_ms;
      logic [15:0] exit_cooldown_ms;
      logic [11:0] max_displace;
   } cfg_type;

   typedef struct packed {
      req_type req;
      cls_type cls;
   } qent_type;

   // arctangent of 2^-i in Q30, truncated
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:    v = 30'h3243F6A8;
         5'd1:    v = 30'h1DAC6705;
         5'd2:    v = 30'h0FADBAFC;
         5'd3:    v = 30'h07F56EA6;
         5'd4:    v = 30'h03FEAB76;
         5'd5:    v = 30'h01FFD55B;
         5'd6:    v = 30'h00FFFAAA;
         5'd7:    v = 30'h007FFF55;
         5'd8:    v = 30'h003FFFEA;
         5'd9:    v = 30'h001FFFFD;
         5'd10:   v = 30'h000FFFFF;
         5'd11:   v = 30'h0007FFFF;
         5'd12:   v = 30'h0003FFFF;
         5'd13:   v = 30'h0001FFFF;
         5'd14:   v = 30'h0000FFFF;
         5'd15:   v = 30'h00007FFF;
         5'd16:   v = 30'h00003FFF;
         5'd17:   v = 30'h00001FFF;
         5'd18:   v = 30'h00000FFF;
         5'd19:   v = 30'h000007FF;
         5'd20:   v = 30'h000003FF;
         5'd21:   v = 30'h000001FF;
         5'd22:   v = 30'h000000FF;
         5'd23:   v = 30'h0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/sgs_front.sv
// request intake: classification and a two-entry queue toward the back end
module sgs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sgs_pkg::req_type  req_data,
   output logic              q_valid,
   output sgs_pkg::qent_type q_data,
   input  logic              q_pop
);
   import sgs_pkg::*;

   qent_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   qent_type   ent;
   logic       push;
   logic       small_x, small_y;

   // classify the request
   assign small_x = (req_data.dx == 16'sd0) || (req_data.dx == 16'sd1) ||
                    (req_data.dx == -16'sd1);
   assign small_y = (req_data.dy == 16'sd0) || (req_data.dy == 16'sd1) ||
                    (req_data.dy == -16'sd1);

   always_comb begin
      ent.req = req_data;
      if (!req_data.detect_enabled) begin
         ent.cls = CLS_OFF;
      end else if (req_data.drag_mode || req_data.buttons_held) begin
         ent.cls = CLS_BUTTON;
      end else if (small_x && small_y) begin
         ent.cls = CLS_NOISE;
      end else begin
         ent.cls = CLS_MOTION;
      end
   end

   // queue pointers
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

>>> hw/rtl/sgs_cordic.sv
// iterative vectoring cordic: atan2(y, x) one rotation per cycle
module sgs_cordic (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [sgs_pkg::PROD_W-1:0]      y_val,
   input  logic signed [sgs_pkg::PROD_W-1:0]      x_val,
   output logic                                   busy,
   output logic signed [sgs_pkg::DTH_W-1:0]       angle
);
   import sgs_pkg::*;

   localparam int CS_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int SH   = 30 - ANGLE_FRAC_BITS;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic                       zero_ff, zero_in;
   logic                       busy_ff, busy_in;
   logic [CS_W-1:0]            cnt_ff, cnt_in;
   logic signed [CORDIC_W-1:0] xe, ye, xs, ys;
   logic signed [Z_W-1:0]      at, zr;

   assign xe = CORDIC_W'(x_val);
   assign ye = CORDIC_W'(y_val);
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = $signed({{(Z_W-30){1'b0}}, atan_q30(5'(cnt_ff))});

   // load with quadrant pre-rotation, then one rotation per cycle
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         zero_in = (x_val == '0) && (y_val == '0);
         busy_in = 1'b1;
         cnt_in  = '0;
         if (!xe[CORDIC_W-1]) begin
            x_in = xe;
            y_in = ye;
            z_in = '0;
         end else if (!ye[CORDIC_W-1]) begin
            x_in = ye;
            y_in = -xe;
            z_in = $signed(Q30_HALF_PI);
         end else begin
            x_in = -ye;
            y_in = xe;
            z_in = -$signed(Q30_HALF_PI);
         end
      end else if (busy_ff) begin
         if (!y_ff[CORDIC_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CS_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
   end

   // round half up to the angle format
   assign zr    = (z_ff + Z_W'(1 << (SH - 1))) >>> SH;
   assign busy  = busy_ff;
   assign angle = zero_ff ? '0 : zr[DTH_W-1:0];

endmodule

>>> hw/rtl/sgs_isqrt.sv
// bit-pair integer square root, one result bit per cycle
module sgs_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sgs_pkg::SQ_IN_W-1:0]    n_val,
   output logic                           busy,
   output logic [sgs_pkg::SQ_OUT_W-1:0]   root
);
   import sgs_pkg::*;

   localparam int CNT_W = $clog2(SQ_OUT_W);

   logic [SQ_IN_W-1:0] n_ff, n_in, r_ff, r_in, b_ff, b_in;
   logic [SQ_IN_W:0]   trial;
   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign trial = {1'b0, r_ff} + {1'b0, b_ff};

   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         n_in    = n_val;
         r_in    = '0;
         b_in    = SQ_IN_W'(1) << (SQ_IN_W - 2);
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in = n_ff - trial[SQ_IN_W-1:0];
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SQ_OUT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[SQ_OUT_W-1:0];

endmodule

>>> hw/rtl/sgs_back.sv
// execution sequencer: stroke accumulators, arming decision and scroll output
module sgs_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sgs_pkg::cfg_type                     cfg,
   input  logic                                 q_valid,
   input  sgs_pkg::qent_type                    q_data,
   output logic                                 q_pop,
   output logic                                 unit_start,
   output logic signed [sgs_pkg::PROD_W-1:0]    cor_y,
   output logic signed [sgs_pkg::PROD_W-1:0]    cor_x,
   input  logic                                 cor_busy,
   input  logic signed [sgs_pkg::DTH_W-1:0]     cor_angle,
   output logic [sgs_pkg::SQ_IN_W-1:0]          isq_n,
   input  logic                                 isq_busy,
   input  logic [sgs_pkg::SQ_OUT_W-1:0]         isq_root,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sgs_pkg::rsp_type                     rsp_data
);
   import sgs_pkg::*;

   back_state_type     st_ff, st_in;
   logic [1:0]         cnt_ff, cnt_in;
   req_type            item_ff, item_in;
   cls_type            cls_ff, cls_in;
   rsp_type            res_ff, res_in;
   logic signed [23:0] angle_sum_ff, angle_sum_in;
   logic [23:0]        abs_sum_ff, abs_sum_in;
   logic [23:0]        path_ff, path_in;
   logic signed [17:0] netx_ff, netx_in, nety_ff, nety_in;
   logic signed [15:0] prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic               have_prev_ff, have_prev_in;
   logic               armed_ff, armed_in;
   logic signed [19:0] frac_ff, frac_in;
   logic [15:0]        last_motion_ff, last_motion_in;
   logic [15:0]        last_exit_ff, last_exit_in;
   logic [15:0]        stroke_start_ff, stroke_start_in;
   logic               seeded_ff, seeded_in;
   logic signed [PROD_W-1:0] dot_ff, dot_in, crs_ff, crs_in;
   logic [31:0]        mag_ff, mag_in;
   logic [36:0]        d2_ff, d2_in;
   logic [23:0]        lim_ff, lim_in;
   logic [35:0]        rad_ff, rad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               restart, leave;

   // elapsed times
   logic [15:0] now, since_motion, since_start, since_exit;
   assign now          = item_ff.now_ms;
   assign since_motion = now - last_motion_ff;
   assign since_start  = now - stroke_start_ff;
   assign since_exit   = now - last_exit_ff;

   // shared multiplier
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // accumulator updates with saturation
   logic [23:0]        ang_abs;
   logic signed [24:0] dth_w, asum_w;
   logic signed [23:0] asum_sat;
   logic [24:0]        dth_abs, abs_w, path_w;
   logic signed [18:0] netx_w, nety_w;
   logic signed [17:0] netx_sat, nety_sat;
   assign ang_abs  = angle_sum_ff[23] ? 24'(-angle_sum_ff) : 24'(angle_sum_ff);
   assign dth_w    = 25'(cor_angle);
   assign asum_w   = 25'(angle_sum_ff) + dth_w;
   assign asum_sat = (asum_w > 25'sd8388607) ? 24'sd8388607 :
                     (asum_w < -25'sd8388607) ? -24'sd8388607 : asum_w[23:0];
   assign dth_abs  = dth_w[24] ? 25'(-dth_w) : 25'(dth_w);
   assign abs_w    = {1'b0, abs_sum_ff} + dth_abs;
   assign path_w   = {1'b0, path_ff} + 25'(isq_root);
   assign netx_w   = 19'(netx_ff) + 19'(item_ff.dx);
   assign nety_w   = 19'(nety_ff) + 19'(item_ff.dy);
   assign netx_sat = (netx_w > 19'sd131071) ? 18'sd131071 :
                     (netx_w < -19'sd131071) ? -18'sd131071 : netx_w[17:0];
   assign nety_sat = (nety_w > 19'sd131071) ? 18'sd131071 :
                     (nety_w < -19'sd131071) ? -18'sd131071 : nety_w[17:0];

   // scroll: fraction in quarter units, whole units toward zero
   logic signed [20:0] f_w, f_ext;
   logic signed [19:0] f_sat, f_rem;
   logic [20:0]        f_mag;
   logic [6:0]         u_mag;
   logic signed [7:0]  units;
   logic signed [9:0]  v_w;
   logic signed [7:0]  v_sat;
   assign f_w   = 21'(frac_ff) - 21'(item_ff.dy);
   assign f_sat = (f_w > 21'sd524287) ? 20'sd524287 :
                  (f_w < -21'sd524288) ? -20'sd524288 : f_w[19:0];
   assign f_ext = 21'(f_sat);
   assign f_mag = f_ext[20] ? 21'(-f_ext) : 21'(f_ext);
   assign u_mag = (f_mag[20:2] > 19'd127) ? 7'd127 : f_mag[8:2];
   assign units = f_sat[19] ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
   assign f_rem = f_sat - (20'(units) <<< 2);
   assign v_w   = 10'(item_ff.wheel_v) + 10'(units);
   assign v_sat = (v_w > 10'sd127) ? 8'sd127 : (v_w < -10'sd127) ? -8'sd127 : v_w[7:0];

   // arming test
   logic [CMP_W-1:0] path_lhs, rad_rhs;
   logic             arm_ok, too_far;
   assign path_lhs = CMP_W'(path_ff) << ANGLE_FRAC_BITS;
   assign rad_rhs  = CMP_W'(rad_ff) << 4;
   assign too_far  = d2_ff > {13'b0, lim_ff};
   assign arm_ok   = (since_exit > cfg.exit_cooldown_ms) &&
                     (ang_abs > 24'(cfg.enter_angle)) &&
                     (path_ff > {4'b0, cfg.min_path, 4'b0}) &&
                     (ang_abs > ANG_THR) && (path_lhs < rad_rhs);

   // unit operands
   assign cor_y = crs_ff;
   assign cor_x = dot_ff;
   assign isq_n = {mag_in, 8'b0};

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (st_ff == ST_PROD) begin
         case (cnt_ff)
            2'd0:    begin mul_a = 25'(prevx_ff); mul_b = 25'(item_ff.dx); end
            2'd1:    begin mul_a = 25'(prevy_ff); mul_b = 25'(item_ff.dy); end
            2'd2:    begin mul_a = 25'(prevx_ff); mul_b = 25'(item_ff.dy); end
            default: begin mul_a = 25'(prevy_ff); mul_b = 25'(item_ff.dx); end
         endcase
      end else if (st_ff == ST_DISP) begin
         case (cnt_ff)
            2'd0:    begin mul_a = 25'(netx_ff); mul_b = 25'(netx_ff); end
            2'd1:    begin mul_a = 25'(nety_ff); mul_b = 25'(nety_ff); end
            2'd2: begin
               mul_a = $signed(25'(cfg.max_displace));
               mul_b = $signed(25'(cfg.max_displace));
            end
            default: begin
               mul_a = $signed(25'(cfg.max_radius));
               mul_b = $signed(25'(ang_abs));
            end
         endcase
      end else if (st_ff == ST_WAIT && !unit_start) begin
         mul_a = 25'(item_ff.dx);
         mul_b = 25'(item_ff.dx);
      end else if (st_ff == ST_WAIT) begin
         mul_a = 25'(item_ff.dy);
         mul_b = 25'(item_ff.dy);
      end
   end

   // sequencer
   always_comb begin
      st_in           = st_ff;
      cnt_in          = cnt_ff;
      item_in         = item_ff;
      cls_in          = cls_ff;
      res_in          = res_ff;
      angle_sum_in    = angle_sum_ff;
      abs_sum_in      = abs_sum_ff;
      path_in         = path_ff;
      netx_in         = netx_ff;
      nety_in         = nety_ff;
      prevx_in        = prevx_ff;
      prevy_in        = prevy_ff;
      have_prev_in    = have_prev_ff;
      armed_in        = armed_ff;
      frac_in         = frac_ff;
      last_motion_in  = last_motion_ff;
      last_exit_in    = last_exit_ff;
      stroke_start_in = stroke_start_ff;
      seeded_in       = seeded_ff;
      dot_in          = dot_ff;
      crs_in          = crs_ff;
      mag_in          = mag_ff;
      d2_in           = d2_ff;
      lim_in          = lim_ff;
      rad_in          = rad_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      q_pop           = 1'b0;
      unit_start      = 1'b0;
      restart         = 1'b0;
      leave           = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_data.req;
               cls_in  = q_data.cls;
               // the first request seeds the time stamps
               if (!seeded_ff) begin
                  last_motion_in  = q_data.req.now_ms;
                  last_exit_in    = q_data.req.now_ms;
                  stroke_start_in = q_data.req.now_ms;
                  seeded_in       = 1'b1;
               end
               st_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in.out_x         = item_ff.dx;
            res_in.out_y         = item_ff.dy;
            res_in.out_h         = item_ff.wheel_h;
            res_in.out_v         = item_ff.wheel_v;
            res_in.scroll_active = 1'b0;
            st_in                = ST_OUT;
            case (cls_ff)
               CLS_OFF: begin
                  leave = armed_ff;
               end
               CLS_BUTTON: begin
                  leave          = armed_ff;
                  restart        = !armed_ff;
                  frac_in        = '0;
                  last_motion_in = now;
               end
               CLS_NOISE: begin
                  if (armed_ff) begin
                     res_in.out_x = '0;
                     res_in.out_y = '0;
                     res_in.out_h = '0;
                     leave        = since_motion > cfg.scroll_idle_ms;
                  end else begin
                     restart = since_motion > cfg.stroke_gap_ms;
                  end
               end
               default: begin
                  // real motion: gap check, then scroll or stroke tracking
                  if (armed_ff) begin
                     if (since_motion > cfg.scroll_idle_ms) begin
                        leave   = 1'b1;
                        frac_in = '0;
                        st_in   = ST_AGE;
                     end else begin
                        st_in = ST_SCROLL;
                     end
                  end else begin
                     if (since_motion > cfg.stroke_gap_ms) begin
                        restart = 1'b1;
                        frac_in = '0;
                     end
                     st_in = ST_AGE;
                  end
                  last_motion_in = now;
               end
            endcase
         end
         ST_AGE: begin
            restart = since_start > cfg.stroke_max_ms;
            cnt_in  = '0;
            st_in   = (have_prev_ff && !restart) ? ST_PROD : ST_OUT;
         end
         ST_PROD: begin
            // dot and cross products of previous and current vector
            case (cnt_ff)
               2'd0:    dot_in = $signed(mul_p[PROD_W-1:0]);
               2'd1:    dot_in = dot_ff + $signed(mul_p[PROD_W-1:0]);
               2'd2:    crs_in = $signed(mul_p[PROD_W-1:0]);
               default: crs_in = crs_ff - $signed(mul_p[PROD_W-1:0]);
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // squared magnitude from dx and dy in turn, then both units run
            if (!cor_busy && !isq_busy && cnt_ff == 2'd0) begin
               mag_in = mul_p[31:0];
               cnt_in = 2'd1;
            end else if (cnt_ff == 2'd1) begin
               unit_start = 1'b1;
               mag_in     = mag_ff + mul_p[31:0];
               cnt_in     = 2'd2;
            end else if (!cor_busy && !isq_busy && cnt_ff == 2'd2) begin
               st_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            angle_sum_in = asum_sat;
            abs_sum_in   = abs_w[24] ? 24'hFFFFFF : abs_w[23:0];
            path_in      = path_w[24] ? 24'hFFFFFF : path_w[23:0];
            netx_in      = netx_sat;
            nety_in      = nety_sat;
            cnt_in       = '0;
            st_in        = ST_DISP;
         end
         ST_DISP: begin
            case (cnt_ff)
               2'd0:    d2_in  = mul_p[36:0];
               2'd1:    d2_in  = d2_ff + mul_p[36:0];
               2'd2:    lim_in = mul_p[23:0];
               default: rad_in = mul_p[35:0];
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               st_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (too_far) begin
               restart = 1'b1;
               st_in   = ST_OUT;
            end else if (arm_ok) begin
               armed_in = 1'b1;
               frac_in  = '0;
               st_in    = ST_SCROLL;
            end else begin
               st_in = ST_OUT;
            end
         end
         ST_SCROLL: begin
            frac_in      = f_rem;
            res_in.out_x = '0;
            res_in.out_y = '0;
            res_in.out_h = '0;
            res_in.out_v = v_sat;
            st_in        = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in               = res_ff;
               rsp_data_in.scroll_active = armed_ff;
               rsp_valid_in              = 1'b1;
               if (cls_ff == CLS_MOTION) begin
                  prevx_in     = item_ff.dx;
                  prevy_in     = item_ff.dy;
                  have_prev_in = 1'b1;
               end
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // disarm implies a stroke restart
      if (leave) begin
         armed_in     = 1'b0;
         last_exit_in = now;
         frac_in      = '0;
         restart      = 1'b1;
      end
      if (restart) begin
         angle_sum_in    = '0;
         abs_sum_in      = '0;
         path_in         = '0;
         netx_in         = '0;
         nety_in         = '0;
         have_prev_in    = 1'b0;
         stroke_start_in = now;
      end
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_IDLE;
         angle_sum_ff    <= '0;
         abs_sum_ff      <= '0;
         path_ff         <= '0;
         netx_ff         <= '0;
         nety_ff         <= '0;
         prevx_ff        <= '0;
         prevy_ff        <= '0;
         have_prev_ff    <= 1'b0;
         armed_ff        <= 1'b0;
         frac_ff         <= '0;
         last_motion_ff  <= '0;
         last_exit_ff    <= '0;
         stroke_start_ff <= '0;
         seeded_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         angle_sum_ff    <= angle_sum_in;
         abs_sum_ff      <= abs_sum_in;
         path_ff         <= path_in;
         netx_ff         <= netx_in;
         nety_ff         <= nety_in;
         prevx_ff        <= prevx_in;
         prevy_ff        <= prevy_in;
         have_prev_ff    <= have_prev_in;
         armed_ff        <= armed_in;
         frac_ff         <= frac_in;
         last_motion_ff  <= last_motion_in;
         last_exit_ff    <= last_exit_in;
         stroke_start_ff <= stroke_start_in;
         seeded_ff       <= seeded_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      item_ff     <= item_in;
      cls_ff      <= cls_in;
      res_ff      <= res_in;
      dot_ff      <= dot_in;
      crs_ff      <= crs_in;
      mag_ff      <= mag_in;
      d2_ff       <= d2_in;
      lim_ff      <= lim_in;
      rad_ff      <= rad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/stir_gesture_scroll_detector.sv
// top level of the trackball stir-to-scroll detector
//
// Requests carry one motion report (dx, dy, wheels, button and drag flags,
// detection enable, millisecond time stamp); every request gives exactly one
// response report, in order. Both channels move on valid high and stall low.
// A two-entry request queue and a response register let the intake and the
// output side stall independently of the sequencer.
// Pass-through, noise and button reports pass the decide and output states,
// armed-scroll reports also the scroll state; a tracked stroke report runs
// the product steps, the square root unit (20 result bits, one at a time)
// alongside the 16-step cordic and the check steps (and scroll if it arms).
// Reports are handled one at a time. A stalled response holds; the sequencer
// waits before writing the next one and the queue fills and stalls requests
// after two more. Reset (synchronous, active high) clears all stroke and
// scroll state and loads the register defaults; the first report seeds the
// time stamps. Registers are to be written through csr_we/csr_addr/csr_wdata
// while idle; the block leaves this rule to the user.
`include "stir_gesture_scroll_detector_defines.svh"

module stir_gesture_scroll_detector (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sgs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sgs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [16:0]      csr_wdata
);
   import sgs_pkg::*;

   cfg_type                  cfg_ff, cfg_in;
   logic                     q_valid, q_pop;
   qent_type                 q_data;
   logic                     unit_start, cor_busy, isq_busy;
   logic signed [PROD_W-1:0] cor_y, cor_x;
   logic signed [DTH_W-1:0]  cor_angle;
   logic [SQ_IN_W-1:0]       isq_n;
   logic [SQ_OUT_W-1:0]      isq_root;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_ENTER_ANGLE:      cfg_in.enter_angle      = csr_wdata;
            CSR_MAX_RADIUS:       cfg_in.max_radius       = csr_wdata[11:0];
            CSR_MIN_PATH:         cfg_in.min_path         = csr_wdata[15:0];
            CSR_STROKE_MAX_MS:    cfg_in.stroke_max_ms    = csr_wdata[15:0];
            CSR_SCROLL_IDLE_MS:   cfg_in.scroll_idle_ms   = csr_wdata[15:0];
            CSR_STROKE_GAP_MS:    cfg_in.stroke_gap_ms    = csr_wdata[15:0];
            CSR_EXIT_COOLDOWN_MS: cfg_in.exit_cooldown_ms = csr_wdata[15:0];
            CSR_MAX_DISPLACE:     cfg_in.max_displace     = csr_wdata[11:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_angle      <= 17'd20480;
         cfg_ff.max_radius       <= 12'd392;
         cfg_ff.min_path         <= 16'd250;
         cfg_ff.stroke_max_ms    <= 16'd1500;
         cfg_ff.scroll_idle_ms   <= 16'd600;
         cfg_ff.stroke_gap_ms    <= 16'd250;
         cfg_ff.exit_cooldown_ms <= 16'd200;
         cfg_ff.max_displace     <= 12'd200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   sgs_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .y_val (cor_y),
      .x_val (cor_x),
      .busy  (cor_busy),
      .angle (cor_angle)
   );

   sgs_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .n_val (isq_n),
      .busy  (isq_busy),
      .root  (isq_root)
   );

   sgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .unit_start (unit_start),
      .cor_y      (cor_y),
      .cor_x      (cor_x),
      .cor_busy   (cor_busy),
      .cor_angle  (cor_angle),
      .isq_n      (isq_n),
      .isq_busy   (isq_busy),
      .isq_root   (isq_root),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // sequencer never pops an empty queue
   `SGS_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "request popped from empty queue")
   // units are started only when both are free
   `SGS_ASSERT_NOW(a_start_free, unit_start, !cor_busy && !isq_busy, "unit started while busy")
   // a start keeps both units busy on the next cycle
   `SGS_ASSERT_NEXT(a_start_busy, unit_start, cor_busy && isq_busy, "unit did not start")

endmodule

>>> sim/testbench.sv
// self-checking testbench of the stir-to-scroll detector with a built-in predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sgs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int NUM_PHASES = 8;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [16:0] csr_wdata = '0;

   stir_gesture_scroll_detector DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // arctangent of 2^-i in Q30
   longint atan_tab [16] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

   // 16-point orbit used to build stirs
   int orbit_x [16] = '{16, 15, 11, 6, 0, -6, -11, -15, -16, -15, -11, -6, 0, 6, 11, 15};
   int orbit_y [16] = '{0, 6, 11, 15, 16, 15, 11, 6, 0, -6, -11, -15, -16, -15, -11, -6};

   // predictor state
   cfg_type    cfg;
   longint     ang_sum, abs_ang_sum, path_len, net_dx, net_dy, frac_q2, last_dx, last_dy;
   bit         have_last, scrolling, seeded;
   logic [15:0] t_motion, t_exit, t_start;

   rsp_type    pending_rsp [$];
   int         fail_count = 0;
   int         items_sent = 0;
   int         rsp_seen = 0;
   int         arm_count = 0;
   int         idle_mode = 0;
   int         quiet_cycles = 0;
   logic [15:0] now_t = 16'd100;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } row_type;
   row_type directed [$];

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [15:0] elapsed(logic [15:0] a, logic [15:0] b);
      return a - b;
   endfunction

   function automatic longint turn_of(longint y, longint x);
      longint z, t, xs, ys;
      int i;
      z = 0;
      if (x == 0 && y == 0) return 0;
      // pre-rotate the left half plane by a quarter turn
      if (x < 0) begin
         if (y >= 0) begin
            t = y; y = -x; x = t; z = HALF_PI_Q30;
         end else begin
            t = -y; y = x; x = t; z = -HALF_PI_Q30;
         end
      end
      for (i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_tab[i];
         end else begin
            x -= ys; y += xs; z -= atan_tab[i];
         end
      end
      return (z + (64'sd1 <<< 17)) >>> 18;
   endfunction

   function automatic longint root_of(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic void restart_stroke(logic [15:0] now);
      ang_sum = 0; abs_ang_sum = 0; path_len = 0; net_dx = 0; net_dy = 0;
      have_last = 0;
      t_start = now;
   endfunction

   function automatic void leave_scroll(logic [15:0] now);
      scrolling = 0;
      t_exit = now;
      frac_q2 = 0;
      restart_stroke(now);
   endfunction

   function automatic void predictor_reset();
      cfg.enter_angle = 17'd20480; cfg.max_radius = 12'd392; cfg.min_path = 16'd250;
      cfg.stroke_max_ms = 16'd1500; cfg.scroll_idle_ms = 16'd600;
      cfg.stroke_gap_ms = 16'd250; cfg.exit_cooldown_ms = 16'd200;
      cfg.max_displace = 12'd200;
      ang_sum = 0; abs_ang_sum = 0; path_len = 0; net_dx = 0; net_dy = 0;
      last_dx = 0; last_dy = 0; have_last = 0; scrolling = 0; seeded = 0;
      frac_q2 = 0; t_motion = 0; t_exit = 0; t_start = 0;
   endfunction

   // expected report for one request, advancing the predictor state
   function automatic rsp_type scroll_report(req_type r);
      rsp_type o;
      longint dx, dy, wv, ox, oy, oh, ov, units, dth, a;
      longint unsigned mag2, d2;
      logic [15:0] now;
      dx = r.dx; dy = r.dy; wv = r.wheel_v;
      now = r.now_ms;
      ox = dx; oy = dy; oh = r.wheel_h; ov = wv;
      mag2 = dx * dx + dy * dy;
      if (!seeded) begin
         t_motion = now; t_exit = now; t_start = now; seeded = 1;
      end
      if (!r.detect_enabled) begin
         if (scrolling) leave_scroll(now);
      end else if (r.drag_mode || r.buttons_held) begin
         if (scrolling) leave_scroll(now);
         else restart_stroke(now);
         frac_q2 = 0;
         t_motion = now;
      end else if (mag2 < 4) begin
         if (scrolling) begin
            ox = 0; oy = 0; oh = 0;
            if (elapsed(now, t_motion) > cfg.scroll_idle_ms) leave_scroll(now);
         end else if (elapsed(now, t_motion) > cfg.stroke_gap_ms) begin
            restart_stroke(now);
         end
      end else begin
         if (elapsed(now, t_motion) > (scrolling ? cfg.scroll_idle_ms : cfg.stroke_gap_ms))
         begin
            if (scrolling) leave_scroll(now);
            else restart_stroke(now);
            frac_q2 = 0;
         end
         t_motion = now;
         if (!scrolling) begin
            if (elapsed(now, t_start) > cfg.stroke_max_ms) restart_stroke(now);
            if (have_last) begin
               dth = turn_of(last_dx * dy - last_dy * dx, last_dx * dx + last_dy * dy);
               ang_sum = clampv(ang_sum + dth, -8388607, 8388607);
               abs_ang_sum = clampv(abs_ang_sum + (dth < 0 ? -dth : dth), 0, 24'hFFFFFF);
               path_len = clampv(path_len + root_of(mag2 << 8), 0, 24'hFFFFFF);
               net_dx = clampv(net_dx + dx, -131071, 131071);
               net_dy = clampv(net_dy + dy, -131071, 131071);
               d2 = net_dx * net_dx + net_dy * net_dy;
               a = ang_sum < 0 ? -ang_sum : ang_sum;
               if (d2 > longint'(cfg.max_displace) * cfg.max_displace) begin
                  restart_stroke(now);
               end else if (elapsed(now, t_exit) > cfg.exit_cooldown_ms
                            && a > cfg.enter_angle
                            && path_len > (longint'(cfg.min_path) << 4)
                            && a > ((3 << 12) / 10)
                            && (path_len << 12) < ((longint'(cfg.max_radius) * a) << 4))
               begin
                  scrolling = 1;
                  frac_q2 = 0;
                  arm_count++;
               end
            end
         end
         // armed reports, including the one that arms, turn -dy into wheel units
         if (scrolling) begin
            frac_q2 = clampv(frac_q2 - dy, -524288, 524287);
            units = clampv(frac_q2 / 4, -127, 127);
            frac_q2 -= units * 4;
            ov = clampv(wv + units, -127, 127);
            ox = 0; oy = 0; oh = 0;
         end
         last_dx = dx; last_dy = dy; have_last = 1;
      end
      o.out_x = ox[15:0]; o.out_y = oy[15:0]; o.out_h = oh[7:0]; o.out_v = ov[7:0];
      o.scroll_active = scrolling;
      return o;
   endfunction

   function automatic req_type mk_req(int dx, int dy, int wv, int wh, bit btn, bit drag,
                                      bit en, int now);
      req_type r;
      r.dx = dx[15:0]; r.dy = dy[15:0]; r.wheel_v = wv[7:0]; r.wheel_h = wh[7:0];
      r.buttons_held = btn; r.drag_mode = drag; r.detect_enabled = en;
      r.now_ms = now[15:0];
      return r;
   endfunction

   function automatic void add_row(req_type r, bit known, rsp_type e);
      row_type w;
      w.r = r; w.known = known; w.e = e;
      directed.push_back(w);
   endfunction

   // send one request, honoring the sender idle mode, and predict its report
   task automatic send(req_type r, bit known = 0, rsp_type e = '0);
      rsp_type p;
      int gap;
      gap = 0;
      if (idle_mode == 1 || idle_mode == 3) begin
         while ($urandom_range(0, 99) < (idle_mode == 1 ? 57 : 16)) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = scroll_report(r);
      pending_rsp.push_back(known ? e : p);
      items_sent++;
   endtask

   task automatic write_cfg(int kind);
      cfg_type c;
      logic [16:0] v;
      int i;
      case (kind)
         0: c = '{17'd20480, 12'd392, 16'd250, 16'd1500, 16'd600, 16'd250, 16'd200, 12'd200};
         1: c = '0;
         2: c = '1;
         default: begin
            c.enter_angle = $urandom_range(4096, 40000);
            c.max_radius = $urandom_range(20, 600);
            c.min_path = $urandom_range(50, 400);
            c.stroke_max_ms = $urandom_range(200, 3000);
            c.scroll_idle_ms = $urandom_range(20, 1000);
            c.stroke_gap_ms = $urandom_range(20, 400);
            c.exit_cooldown_ms = $urandom_range(0, 400);
            c.max_displace = $urandom_range(50, 400);
         end
      endcase
      cfg = c;
      for (i = 0; i < 8; i++) begin
         case (csr_idx_type'(i))
            CSR_ENTER_ANGLE:      v = c.enter_angle;
            CSR_MAX_RADIUS:       v = 17'(c.max_radius);
            CSR_MIN_PATH:         v = 17'(c.min_path);
            CSR_STROKE_MAX_MS:    v = 17'(c.stroke_max_ms);
            CSR_SCROLL_IDLE_MS:   v = 17'(c.scroll_idle_ms);
            CSR_STROKE_GAP_MS:    v = 17'(c.stroke_gap_ms);
            CSR_EXIT_COOLDOWN_MS: v = 17'(c.exit_cooldown_ms);
            default:              v = 17'(c.max_displace);
         endcase
         csr_we <= 1'b1;
         csr_addr <= 3'(i);
         csr_wdata <= v;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // wait until every report is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // one random session: mostly stirs followed by scrolling, plus noise and random reports
   task automatic random_session();
      int kind, n, i, idx, step, scale;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         idx = $urandom_range(0, 15);
         step = $urandom_range(0, 1) ? 1 : -1;
         if ($urandom_range(0, 3) == 0) step *= 2;
         scale = $urandom_range(1, 2);
         n = $urandom_range(15, 40);
         for (i = 0; i < n; i++) begin
            idx = (idx + step + 16) % 16;
            now_t += 16'($urandom_range(1, 8));
            if ($urandom_range(0, 19) == 0)
               send(mk_req($urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1, 0, 0,
                           $urandom_range(0, 3) == 0, 0, 1, now_t));
            else
               send(mk_req(orbit_x[idx] * scale + $urandom_range(0, 2) - 1,
                           orbit_y[idx] * scale + $urandom_range(0, 2) - 1,
                           $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                           0, 0, 1, now_t));
         end
         n = $urandom_range(5, 30);
         for (i = 0; i < n; i++) begin
            now_t += 16'($urandom_range(1, 12));
            if ($urandom_range(0, 39) == 0) now_t += 16'($urandom_range(100, 1200));
            send(mk_req($urandom_range(0, 80) - 40, $urandom_range(0, 200) - 100,
                        $urandom_range(0, 254) - 127, $urandom_range(0, 254) - 127,
                        0, 0, 1, now_t));
         end
      end else if (kind == 6) begin
         n = $urandom_range(2, 8);
         for (i = 0; i < n; i++) begin
            now_t += 16'($urandom_range(0, 400));
            send(mk_req($urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1,
                        $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, 1, now_t));
         end
      end else if (kind == 7) begin
         now_t += 16'($urandom_range(0, 50));
         send(mk_req($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), now_t));
      end else if (kind == 8) begin
         now_t = 16'($urandom);
         send(mk_req($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10, 0, 0, 0, 0, 1,
                     now_t));
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            now_t = 16'($urandom);
            send(mk_req($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                        $urandom_range(0, 1), $urandom_range(0, 1), now_t));
         end
      end
   endtask

   task automatic report_field(string name, longint e, longint a);
      $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, e, a);
      fail_count++;
   endtask

   // response side: random stalls per phase
   always @(posedge clock) begin
      if (idle_mode == 2) rsp_stall <= $urandom_range(0, 99) < 57;
      else if (idle_mode == 3) rsp_stall <= $urandom_range(0, 99) < 16;
      else rsp_stall <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected report %h", $realtime, rsp_data);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (e.out_x !== rsp_data.out_x) report_field("out_x", e.out_x, rsp_data.out_x);
            if (e.out_y !== rsp_data.out_y) report_field("out_y", e.out_y, rsp_data.out_y);
            if (e.out_h !== rsp_data.out_h) report_field("out_h", e.out_h, rsp_data.out_h);
            if (e.out_v !== rsp_data.out_v) report_field("out_v", e.out_v, rsp_data.out_v);
            if (e.scroll_active !== rsp_data.scroll_active)
               report_field("scroll_active", e.scroll_active, rsp_data.scroll_active);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog expired with %0d reports pending", $realtime,
                  pending_rsp.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      rsp_type e;
      int phase, start, i;
      predictor_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: pass-through cases have their report typed in
      e = '{16'sh7FFF, -16'sh8000, 8'sh7F, -8'sh80, 1'b0};
      add_row(mk_req(32767, -32768, -128, 127, 0, 0, 0, 65530), 1, e);
      e = '{-16'sh8000, 16'sh7FFF, -8'sh80, 8'sh7F, 1'b0};
      add_row(mk_req(-32768, 32767, 127, -128, 1, 0, 1, 65535), 1, e);
      e = '{16'sh0005, 16'sh0005, 8'sh01, 8'sh01, 1'b0};
      add_row(mk_req(5, 5, 1, 1, 0, 1, 1, 0), 1, e);
      e = '{16'sh0001, -16'sh0001, 8'sh00, 8'sh00, 1'b0};
      add_row(mk_req(1, -1, 0, 0, 0, 0, 1, 2), 1, e);
      e = '0;
      add_row(mk_req(0, 0, 0, 0, 0, 0, 1, 3), 1, e);
      add_row(mk_req(-32768, -32768, 0, 0, 0, 0, 1, 4), 0, e);
      add_row(mk_req(32767, 32767, 0, 0, 0, 0, 1, 5), 0, e);
      add_row(mk_req(-32768, 0, 0, 0, 0, 0, 1, 6), 0, e);
      add_row(mk_req(10, 0, 0, 0, 0, 0, 1, 7), 0, e);
      add_row(mk_req(-10, 0, 0, 0, 0, 0, 1, 8), 0, e);
      add_row(mk_req(0, -10, 0, 0, 0, 0, 1, 9), 0, e);
      add_row(mk_req(10, 0, 0, 0, 0, 0, 1, 10), 0, e);
      add_row(mk_req(0, 10, 0, 0, 0, 0, 1, 2000), 0, e);
      add_row(mk_req(2, 0, 0, 0, 0, 0, 1, 2001), 0, e);
      for (i = 0; i < 20; i++)
         add_row(mk_req(orbit_x[i % 16] * 2, orbit_y[i % 16] * 2, 0, 0, 0, 0, 1, 2003 + i),
                 0, e);
      foreach (directed[k]) send(directed[k].r, directed[k].known, directed[k].e);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         idle_mode = phase / 2;
         write_cfg(phase % 4);
         start = items_sent;
         while (items_sent - start < ITEMS_PER_PHASE) random_session();
      end
      drain();

      $display("tb: %0d requests, %0d reports checked, %0d scroll arms predicted",
               items_sent, rsp_seen, arm_count);
      $display("tb: %0d register settings over four idle and stall patterns", NUM_PHASES);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
